[sv/keyframe_bracket_search_assert.svh]
// Assertion macros for the keyframe bracket search checker.
// Both macros expect clk and arst_n in scope.
`ifndef KEYFRAME_BRACKET_SEARCH_ASSERT_SVH
`define KEYFRAME_BRACKET_SEARCH_ASSERT_SVH

// Same-cycle implication, held off during reset
`define KBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyframe_bracket_search: assertion failed");

// Next-cycle implication, held off during reset
`define KBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyframe_bracket_search: assertion failed");

`endif

[sv/kbs_pkg.sv]
`default_nettype none
package kbs_pkg;

	// Operation codes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Track codes
	localparam logic [1:0] TRK_POS  = 2'd0;
	localparam logic [1:0] TRK_ROT  = 2'd1;
	localparam logic [1:0] TRK_SCL  = 2'd2;
	localparam logic [1:0] TRK_NONE = 2'd3;

	localparam int NUM_TRACKS = 3;

	// 1.0 in 16.16
	localparam logic [31:0] FIX_ONE = 32'h0001_0000;

	typedef struct packed {
		logic [1:0]         operation;
		logic [1:0]         track;
		logic [31:0]        new_key_time;
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
		logic signed [31:0] comp_w;
		logic [31:0]        query_time;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        out_key_time;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic               is_upper_key;
		logic [31:0]        anim_length;
	} out_item_t;

	// One stored key, one memory word
	typedef struct packed {
		logic [31:0] key_time;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
	} key_t;

	// Query request handed from the front end to the sequencer
	typedef struct packed {
		logic [1:0]  trk;
		logic [31:0] qt;
		logic [31:0] len;
	} qry_t;

endpackage
`default_nettype wire

[sv/kbs_ram.sv]
`default_nettype none
module kbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[sv/kbs_ctrl.sv]
`default_nettype none
module kbs_ctrl #(
	parameter int MAX_KEYS = 64,
	localparam int AW = $clog2(3 * MAX_KEYS),
	localparam int CW = $clog2(MAX_KEYS + 1),
	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire kbs_pkg::qry_t     qry,
	input  wire logic [CW-1:0]     key_count,
	input  wire logic [AW-1:0]     base_addr,
	output logic                   busy,
	output logic                   rd_en,
	output logic      [AW-1:0]     rd_addr,
	input  wire kbs_pkg::key_t     rd_data,
	output logic                   done,
	output kbs_pkg::out_item_t     result
);
	import kbs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RDLO = 3'd2;
	localparam logic [2:0] S_EMLO = 3'd3;
	localparam logic [2:0] S_EMHI = 3'd4;
	localparam logic [2:0] S_DEF0 = 3'd5;
	localparam logic [2:0] S_DEF1 = 3'd6;

	logic [2:0]    state_q;
	logic [1:0]    trk_q;
	logic [31:0]   qt_q;
	logic [31:0]   len_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] dat_q;
	logic          prev_le_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic          done_q;
	out_item_t     res_q;

	logic [CW-1:0] nxt;
	logic          cmp_lt;
	logic          cmp_eq;
	logic          found;
	logic [31:0]   dflt_v;

	// Shared compare unit: stored key time against the query time
	always_comb begin
		cmp_lt = rd_data.key_time < qt_q;
		cmp_eq = rd_data.key_time == qt_q;
		found  = prev_le_q && !cmp_lt;
		nxt    = CW'(dat_q + 1'b1);
		dflt_v = (trk_q == TRK_SCL) ? FIX_ONE : 32'd0;
	end

	// Memory read requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = base_q;
		case (state_q)
			S_IDLE: begin
				rd_en   = go;
				rd_addr = base_addr;
			end
			S_SCAN: begin
				rd_en   = nxt < n_q;
				rd_addr = AW'(base_q + AW'(nxt[IW-1:0]));
			end
			S_RDLO: begin
				rd_en   = 1'b1;
				rd_addr = AW'(base_q + AW'(lo_q));
			end
			S_EMLO: begin
				rd_en   = 1'b1;
				rd_addr = AW'(base_q + AW'(hi_q));
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = base_q;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (go) begin
						state_q <= (key_count == '0) ? S_DEF0 : S_SCAN;
					end
				end
				S_SCAN: begin
					if (found || nxt == n_q) begin
						state_q <= S_RDLO;
					end
				end
				S_RDLO: state_q <= S_EMLO;
				S_EMLO: begin
					state_q <= S_EMHI;
					done_q  <= 1'b1;
				end
				S_EMHI: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_DEF0: begin
					state_q <= S_DEF1;
					done_q  <= 1'b1;
				end
				S_DEF1: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query context and scan progress
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && go) begin
			trk_q     <= qry.trk;
			qt_q      <= qry.qt;
			len_q     <= qry.len;
			n_q       <= key_count;
			base_q    <= base_addr;
			dat_q     <= '0;
			prev_le_q <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			dat_q     <= nxt;
			prev_le_q <= cmp_lt || cmp_eq;
			if (found) begin
				lo_q <= IW'(dat_q - 1'b1);
				hi_q <= dat_q[IW-1:0];
			end else begin
				lo_q <= '0;
				hi_q <= '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_EMLO, S_EMHI: begin
				res_q.out_key_time <= rd_data.key_time;
				res_q.out_x        <= rd_data.x;
				res_q.out_y        <= rd_data.y;
				res_q.out_z        <= rd_data.z;
				res_q.out_w        <= (trk_q == TRK_ROT) ? rd_data.w : 32'd0;
				res_q.is_upper_key <= state_q == S_EMHI;
				res_q.anim_length  <= len_q;
			end
			S_DEF0, S_DEF1: begin
				res_q.out_key_time <= 32'd0;
				res_q.out_x        <= dflt_v;
				res_q.out_y        <= dflt_v;
				res_q.out_z        <= dflt_v;
				res_q.out_w        <= (trk_q == TRK_ROT) ? FIX_ONE : 32'd0;
				res_q.is_upper_key <= state_q == S_DEF1;
				res_q.anim_length  <= len_q;
			end
			default: res_q <= res_q;
		endcase
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

[sv/keyframe_bracket_search.sv]
// keyframe_bracket_search
// Holds three key tracks (position, rotation, scaling) of up to MAX_KEYS keys
// each and answers bracket queries on them.
// Input: drive item and raise start; the item is taken on a rising edge with
// start high and busy low. A clear or an append gives no result. A query on
// track three or an operation code three is taken and has no effect.
// A query walks its track one stored key per cycle through a single compare
// unit fed by the key memory's read port, then reads the two bracketing keys
// back. The scan stops at the first bracketing pair or after the last key;
// an empty track skips the scan and gives default keys. busy is high until
// the upper key is shown.
// Output: each result shows on result for one cycle with done high, lower key
// first, then the upper key with is_upper_key set; the upper key appears the
// cycle busy falls. The receiver cannot stall; results are never held.
// Reset empties all tracks at once; key memory contents are not cleared.
`default_nettype none
module keyframe_bracket_search #(
	parameter int MAX_KEYS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire kbs_pkg::in_item_t     item,
	output logic                       done,
	output kbs_pkg::out_item_t         result
);
	import kbs_pkg::*;

	localparam int AW = $clog2(3 * MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam logic [AW-1:0] BASE1 = AW'(MAX_KEYS);
	localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_KEYS);

	logic [CW-1:0] cnt_q [NUM_TRACKS];
	logic [31:0]   last_q [NUM_TRACKS];

	logic          acc;
	logic          trk_ok;
	logic [CW-1:0] cur_cnt;
	logic [AW-1:0] trk_base;
	logic          app_we;
	logic          go;
	logic [31:0]   c0;
	logic [31:0]   c1;
	logic [31:0]   c2;
	logic [31:0]   m01;
	qry_t          qry;
	key_t          wr_key;
	key_t          rd_key;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// Item decode
	always_comb begin
		acc    = start && !busy;
		trk_ok = item.track inside {TRK_POS, TRK_ROT, TRK_SCL};
		case (item.track)
			TRK_POS: begin
				cur_cnt  = cnt_q[0];
				trk_base = '0;
			end
			TRK_ROT: begin
				cur_cnt  = cnt_q[1];
				trk_base = BASE1;
			end
			TRK_SCL: begin
				cur_cnt  = cnt_q[2];
				trk_base = BASE2;
			end
			default: begin
				cur_cnt  = '0;
				trk_base = '0;
			end
		endcase
		app_we = acc && item.operation == OP_APPEND && trk_ok &&
			cur_cnt < CW'(MAX_KEYS);
		go     = acc && item.operation == OP_QUERY && trk_ok;
	end

	// Animation length: largest last-key time of the non-empty tracks
	always_comb begin
		c0  = (cnt_q[0] != '0) ? last_q[0] : 32'd0;
		c1  = (cnt_q[1] != '0) ? last_q[1] : 32'd0;
		c2  = (cnt_q[2] != '0) ? last_q[2] : 32'd0;
		m01 = (c1 > c0) ? c1 : c0;
		qry.trk = item.track;
		qry.qt  = item.query_time;
		qry.len = (c2 > m01) ? c2 : m01;
	end

	// Key counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TRACKS; t++) begin
				cnt_q[t] <= '0;
			end
		end else if (acc && item.operation == OP_CLEAR) begin
			for (int t = 0; t < NUM_TRACKS; t++) begin
				cnt_q[t] <= '0;
			end
		end else if (app_we) begin
			cnt_q[item.track] <= CW'(cur_cnt + 1'b1);
		end
	end

	// Time of the last key per track
	always_ff @(posedge clk) begin
		if (app_we) begin
			last_q[item.track] <= item.new_key_time;
		end
	end

	assign wr_key.key_time = item.new_key_time;
	assign wr_key.x        = item.comp_x;
	assign wr_key.y        = item.comp_y;
	assign wr_key.z        = item.comp_z;
	assign wr_key.w        = item.comp_w;

	kbs_ram #(
		.WIDTH ($bits(key_t)),
		.DEPTH (3 * MAX_KEYS)
	) u_keys (
		.clk     (clk),
		.wr_en   (app_we),
		.wr_addr (AW'(trk_base + AW'(cur_cnt[IW-1:0]))),
		.wr_data (wr_key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_key)
	);

	kbs_ctrl #(
		.MAX_KEYS (MAX_KEYS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.qry       (qry),
		.key_count (cur_cnt),
		.base_addr (trk_base),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_key),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

[sv/kbs_checker.sv]
`default_nettype none
`include "keyframe_bracket_search_assert.svh"
module kbs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire kbs_pkg::in_item_t  item,
	input wire logic               done,
	input wire kbs_pkg::out_item_t result
);
	import kbs_pkg::*;

	logic q_take;
	logic other_take;

	assign q_take = start && !busy && item.operation == OP_QUERY &&
		(item.track == TRK_POS || item.track == TRK_ROT || item.track == TRK_SCL);
	assign other_take = start && !busy && item.operation != OP_QUERY;

	// A valid query always occupies the block
	`KBS_ASSERT_NXT(a_query_busy, q_take, busy)
	// Lower key is followed at once by the upper key of the same length
	`KBS_ASSERT_NXT(a_pair, done && !result.is_upper_key,
		done && result.is_upper_key && result.anim_length == $past(result.anim_length))
	// Upper key closes the item
	`KBS_ASSERT_NOW(a_upper_idle, done && result.is_upper_key, !busy)
	// Clear, append and no-op give no result and no busy time
	`KBS_ASSERT_NXT(a_quiet_ops, other_take, !busy && !done)

endmodule

bind keyframe_bracket_search kbs_checker u_kbs_checker (.*);
`default_nettype wire
